### rtl/brte_pkg.sv
// ============================================================================
// brte_pkg
// Types and calendar tables shared by the RTC snapshot to epoch converter.
// ============================================================================
`default_nettype none

package brte_pkg;

    // One RTC register snapshot.
    typedef struct packed {
        logic [7:0] seconds_reg;
        logic [7:0] minutes_reg;
        logic [7:0] hours_reg;
        logic [7:0] day_reg;
        logic [7:0] month_reg;
        logic [7:0] year_reg;
        logic [7:0] flag_reg;
        logic [7:0] control_reg;
    } t_in;

    // One converted result.
    typedef struct packed {
        logic        valid_res;
        logic [32:0] epoch_seconds;
    } t_out;

    localparam logic [11:0] MIN_YEAR_RESET = 12'd2025;
    localparam logic [11:0] BASE_YEAR      = 12'd2000;
    // Days from 1970-01-01 to 2000-01-01.
    localparam logic [16:0] DAYS_TO_2000   = 17'd10957;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam int          FLAG_VLOW_BIT  = 1;
    localparam int          CTRL_STOP_BIT  = 6;

    // High nibble times ten plus low nibble; non-decimal nibbles are decoded by the same formula.
    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
    endfunction

    // Days in the months before this one, in a common year.
    function automatic logic [8:0] days_before_month(input logic [4:0] m);
        logic [8:0] d;
        unique case (m)
            5'd1:    d = 9'd0;
            5'd2:    d = 9'd31;
            5'd3:    d = 9'd59;
            5'd4:    d = 9'd90;
            5'd5:    d = 9'd120;
            5'd6:    d = 9'd151;
            5'd7:    d = 9'd181;
            5'd8:    d = 9'd212;
            5'd9:    d = 9'd243;
            5'd10:   d = 9'd273;
            5'd11:   d = 9'd304;
            5'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of a month; zero for a month number that does not exist.
    function automatic logic [4:0] month_len(input logic [4:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: d = 5'd31;
            5'd4, 5'd6, 5'd9, 5'd11:                   d = 5'd30;
            5'd2:                                      d = leap ? 5'd29 : 5'd28;
            default:                                   d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/bcd_rtc_to_epoch_seconds_top.sv
// ============================================================================
// bcd_rtc_to_epoch_seconds_top
// Converts a BCD RTC register snapshot into a validity bit and Unix seconds.
// ============================================================================
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ---------------------------
//  in       sink       i_in_valid / o_in_stall    i_in_data  (t_in)
//  out      source     o_out_valid / i_out_stall  o_out_data (t_out)
//  cfg      sink       i_cfg_wr_en                i_cfg_wr_data (min_year)
//
//  Four register stages: BCD decode, range checks with day count, day to
//  seconds multiply, final add. One item can enter every cycle unless
//  o_in_stall is high. Each stage holds its item while the stage after it
//  is full and stalled, so a stall on the output backs up stage by stage and
//  reaches o_in_stall only when all four stages are full. Reset clears the
//  stage valid bits and returns min_year to 2025.
//
`default_nettype none

module bcd_rtc_to_epoch_seconds_top
    import brte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [11:0] i_cfg_wr_data
);

    logic [11:0] r_min_year;

    logic en1, en2, en3, en4;

    // Stage 1: decoded fields.
    logic       r_v1;
    logic [6:0] r_sec1, r_min1;
    logic [5:0] r_hour1, r_day1;
    logic [4:0] r_mon1;
    logic [7:0] r_yo1;
    logic       r_bad1;

    // Stage 2: checks and day count.
    logic        r_v2, r_ok2;
    logic [16:0] r_days2, r_tod2;
    logic        n_ok2;
    logic [16:0] n_days2, n_tod2;
    logic        leap2;
    logic [4:0]  last2;
    logic [7:0]  leaps2;
    logic [11:0] year2;

    // Stage 3: days in seconds.
    logic        r_v3, r_ok3;
    logic [32:0] r_prod3;
    logic [16:0] r_tod3;

    // Stage 4: output register.
    logic        r_v4;
    t_out        r_out4;

    assign en4 = !r_v4 || !i_out_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign o_out_valid = r_v4;
    assign o_out_data  = r_out4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_year <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_sec1  <= 7'(bcd_dec({1'b0, i_in_data.seconds_reg[6:0]}));
            r_min1  <= 7'(bcd_dec({1'b0, i_in_data.minutes_reg[6:0]}));
            r_hour1 <= 6'(bcd_dec({2'b0, i_in_data.hours_reg[5:0]}));
            r_day1  <= 6'(bcd_dec({2'b0, i_in_data.day_reg[5:0]}));
            r_mon1  <= 5'(bcd_dec({3'b0, i_in_data.month_reg[4:0]}));
            r_yo1   <= bcd_dec(i_in_data.year_reg);
            r_bad1  <= i_in_data.flag_reg[FLAG_VLOW_BIT]
                     | i_in_data.control_reg[CTRL_STOP_BIT];
        end
    end

    // Within 2000..2165 only 2100 breaks the every-fourth-year rule.
    always_comb begin
        leap2  = (r_yo1[1:0] == 2'd0) && (r_yo1 != 8'd100);
        last2  = month_len(r_mon1, leap2);
        year2  = {4'd0, r_yo1} + BASE_YEAR;
        // Leap days in the years 2000 up to the year before this one.
        leaps2 = 8'(({1'b0, r_yo1} + 9'd3) >> 2) - ((r_yo1 > 8'd100) ? 8'd1 : 8'd0);
        n_ok2  = !r_bad1
              && (r_mon1 >= 5'd1) && (r_mon1 <= 5'd12)
              && (r_day1 != 6'd0) && (r_day1 <= {1'b0, last2})
              && (year2 >= r_min_year)
              && (r_hour1 <= 6'd23) && (r_min1 <= 7'd59) && (r_sec1 <= 7'd59);
        n_days2 = DAYS_TO_2000
                + 17'(r_yo1 * 17'd365)
                + {9'd0, leaps2}
                + {8'd0, days_before_month(r_mon1)}
                + {16'd0, leap2 && (r_mon1 > 5'd2)}
                + {11'd0, r_day1} - 17'd1;
        n_tod2 = 17'(r_hour1 * 17'd3600) + 17'(r_min1 * 17'd60) + {10'd0, r_sec1};
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_ok2   <= n_ok2;
            r_days2 <= n_days2;
            r_tod2  <= n_tod2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_ok3   <= r_ok2;
            r_prod3 <= {16'd0, r_days2} * {16'd0, SECS_PER_DAY};
            r_tod3  <= r_tod2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out4.valid_res     <= r_ok3;
            r_out4.epoch_seconds <= r_ok3 ? (r_prod3 + {16'd0, r_tod3}) : 33'd0;
        end
    end

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.valid_res) |-> (o_out_data.epoch_seconds == 33'd0))
        else $error("invalid result carries a nonzero epoch");

    a_valid_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.valid_res) |-> (o_out_data.epoch_seconds >= 33'd946684800))
        else $error("valid result lies before the year 2000");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled while a stage is empty");

    a_hold_stage3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_v3 && i_out_stall) |=> (r_v3 && $stable(r_prod3)))
        else $error("stage three lost its item under a stall");

    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_ok3) |-> (r_tod3 < SECS_PER_DAY))
        else $error("time of day out of range on a valid item");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the BCD RTC snapshot to epoch seconds converter.
// Snapshots are queued by the main sequence, offered by a clocked driver with
// random gaps, and every result is checked in order against a calendar
// predictor that tracks the min_year register. The run covers several
// min_year settings, a long output hold-off and a phase without idling.
// ============================================================================

module tb_top;
    import brte_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int IDLE_PCT     = 25;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] SEC_MASK   = 8'h7F;
    localparam logic [7:0] MIN_MASK   = 8'h7F;
    localparam logic [7:0] HOUR_MASK  = 8'h3F;
    localparam logic [7:0] DAY_MASK   = 8'h3F;
    localparam logic [7:0] MONTH_MASK = 8'h1F;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_wr_en;
    logic [11:0] i_cfg_wr_data;

    t_in         snap_queue[$];
    t_out        epoch_due[$];
    logic [11:0] floor_year;
    bit          in_took;
    bit          quiet;
    bit          hold_req;
    int          hold_left;
    int          errors;
    int          idle_cycles;

    bcd_rtc_to_epoch_seconds_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int bcd_val(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(input int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return 28;
            default:               return 0;
        endcase
    endfunction

    // Expected conversion of one snapshot under the given minimum year.
    function automatic t_out epoch_of_snapshot(input t_in s, input logic [11:0] year_floor);
        int   sec, mins, hrs, dd, mm, yy, last, n, days;
        bit   ok;
        t_out r;
        sec  = bcd_val(s.seconds_reg & SEC_MASK);
        mins = bcd_val(s.minutes_reg & MIN_MASK);
        hrs  = bcd_val(s.hours_reg & HOUR_MASK);
        dd   = bcd_val(s.day_reg & DAY_MASK);
        mm   = bcd_val(s.month_reg & MONTH_MASK);
        yy   = 2000 + bcd_val(s.year_reg);
        ok   = !s.flag_reg[FLAG_VLOW_BIT] && !s.control_reg[CTRL_STOP_BIT];
        if (mm < 1 || mm > 12) begin
            ok = 0;
        end else begin
            last = month_days(mm);
            if (mm == 2 && leap_year(yy)) last = 29;
            if (dd < 1 || dd > last) ok = 0;
        end
        if (yy < int'(year_floor)) ok = 0;
        if (hrs > 23 || mins > 59 || sec > 59) ok = 0;
        r = '0;
        if (ok) begin
            // Days from 1970 to the start of the year, counting leap years from 2000 on.
            n = yy - 2000;
            days = 10957 + 365 * n + (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
            for (int k = 1; k < mm; k++) days += month_days(k);
            if (mm > 2 && leap_year(yy)) days++;
            days += dd - 1;
            r.valid_res     = 1'b1;
            r.epoch_seconds = 33'(longint'(days) * 86400 + hrs * 3600 + mins * 60 + sec);
        end
        return r;
    endfunction

    // BCD encoding; now and then a digit pair is written with a non-decimal low nibble.
    function automatic logic [7:0] bcd_pack(input int v);
        int hi, lo;
        hi = v / 10;
        if (hi > 15) hi = 15;
        lo = v - hi * 10;
        if (hi > 0 && lo <= 5 && $urandom_range(0, 7) == 0) begin
            hi--;
            lo += 10;
        end
        return 8'((hi << 4) | lo);
    endfunction

    function automatic t_in snap(input logic [7:0] s, mi, h, d, mo, y, f, c);
        t_in t;
        t.seconds_reg = s;
        t.minutes_reg = mi;
        t.hours_reg   = h;
        t.day_reg     = d;
        t.month_reg   = mo;
        t.year_reg    = y;
        t.flag_reg    = f;
        t.control_reg = c;
        return t;
    endfunction

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endtask

    // Mostly plausible dates with random content, the rest raw noise.
    task automatic queue_random(input int count);
        t_in s;
        int  lo, yr, mo, dlast, dd, hrs, mins, sec;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 20) begin
                s = t_in'({$urandom, $urandom});
            end else begin
                lo = (floor_year < 2000 || floor_year > 2165) ? 2000 : int'(floor_year);
                yr = ($urandom_range(0, 9) == 0) ? $urandom_range(2000, 2165)
                                                 : $urandom_range(lo, 2165);
                mo = $urandom_range(1, 12);
                dlast = month_days(mo) + ((mo == 2 && leap_year(yr)) ? 1 : 0);
                case ($urandom_range(0, 9))
                    0:       dd = dlast;
                    1:       dd = dlast + 1;
                    default: dd = $urandom_range(1, dlast);
                endcase
                hrs  = ($urandom_range(0, 29) == 0) ? $urandom_range(24, 39) : $urandom_range(0, 23);
                mins = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 79) : $urandom_range(0, 59);
                sec  = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 79) : $urandom_range(0, 59);
                s.seconds_reg = bcd_pack(sec)     | (8'($urandom) & ~SEC_MASK);
                s.minutes_reg = bcd_pack(mins)    | (8'($urandom) & ~MIN_MASK);
                s.hours_reg   = bcd_pack(hrs)     | (8'($urandom) & ~HOUR_MASK);
                s.day_reg     = bcd_pack(dd)      | (8'($urandom) & ~DAY_MASK);
                s.month_reg   = bcd_pack(mo)      | (8'($urandom) & ~MONTH_MASK);
                s.year_reg    = bcd_pack(yr - 2000);
                s.flag_reg    = 8'($urandom);
                s.control_reg = 8'($urandom);
                if ($urandom_range(0, 19) != 0) s.flag_reg[FLAG_VLOW_BIT] = 1'b0;
                if ($urandom_range(0, 19) != 0) s.control_reg[CTRL_STOP_BIT] = 1'b0;
            end
            snap_queue.push_back(s);
        end
    endtask

    task automatic drain();
        while (snap_queue.size() != 0 || epoch_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [11:0] year_floor, input int count, input bit no_gaps);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= year_floor;
        floor_year     = year_floor;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        quiet = no_gaps;
        if (no_gaps) begin
            @(posedge i_clk);
            hold_req = 1'b1;
        end
        queue_random(count);
    endtask

    // Input driver: holds an offered item until it is taken.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_took) begin
            in_took = 1'b0;
            if (snap_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= snap_queue[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            epoch_due.push_back(epoch_of_snapshot(i_in_data, floor_year));
            void'(snap_queue.pop_front());
            in_took = 1'b1;
        end
    end

    // Output stall: random, or held high for a long stretch on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (epoch_due.size() == 0) begin
                report_error($sformatf("unexpected result: valid=%0b epoch=%0d",
                                       o_out_data.valid_res, o_out_data.epoch_seconds));
            end else begin
                want = epoch_due.pop_front();
                if (o_out_data.valid_res !== want.valid_res ||
                    o_out_data.epoch_seconds !== want.epoch_seconds) begin
                    report_error($sformatf("mismatch: expected valid=%0b epoch=%0d, got valid=%0b epoch=%0d",
                                           want.valid_res, want.epoch_seconds,
                                           o_out_data.valid_res, o_out_data.epoch_seconds));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        floor_year    = MIN_YEAR_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed snapshots under the reset minimum year.
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h25, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'hFF, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h28, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h27, 8'h00, 8'h00));
        // Year 2100 is not a leap year.
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'hA0, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h12, 8'h28, 8'h02, 8'hA0, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h96, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h30, 8'h30, 8'h10, 8'h15, 8'h06, 8'h30, 8'h02, 8'h00));
        snap_queue.push_back(snap(8'h30, 8'h30, 8'h10, 8'h15, 8'h06, 8'h30, 8'hFD, 8'h00));
        snap_queue.push_back(snap(8'h30, 8'h30, 8'h10, 8'h15, 8'h06, 8'h30, 8'h00, 8'h40));
        snap_queue.push_back(snap(8'h30, 8'h30, 8'h10, 8'h15, 8'h06, 8'h30, 8'h00, 8'hBF));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h24, 8'h15, 8'h06, 8'h30, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h60, 8'h10, 8'h15, 8'h06, 8'h30, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h60, 8'h00, 8'h10, 8'h15, 8'h06, 8'h30, 8'h00, 8'h00));
        // Non-decimal nibbles decode by the same formula.
        snap_queue.push_back(snap(8'h1F, 8'h1A, 8'h1A, 8'h0F, 8'h0A, 8'h2F, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h10, 8'h00, 8'h06, 8'h30, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h10, 8'h32, 8'h06, 8'h30, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h10, 8'h15, 8'h13, 8'h30, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h10, 8'h31, 8'h04, 8'h30, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h10, 8'h30, 8'h04, 8'h30, 8'h00, 8'h00));
        // Bits above each field's mask are ignored.
        snap_queue.push_back(snap(8'hB0, 8'hD9, 8'hD2, 8'hD5, 8'hE6, 8'h30, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24, 8'h00, 8'h00));
        snap_queue.push_back(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h00, 8'h00));
        queue_random(200);

        run_phase(12'd2000, 250, 1'b1);
        run_phase(12'd2165, 150, 1'b0);
        run_phase(12'd4095, 60, 1'b0);
        run_phase(12'd0, 150, 1'b0);
        run_phase(12'($urandom_range(2000, 2165)), 250, 1'b0);
        run_phase(12'd2050, 250, 1'b0);

        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
